// ----- rtl/sktbl_pkg.sv -----
// ----------------------------------------------------------------------------
// Sorted key table package
// Shared constants, command and status codes, FSM state type and compare
// result type for the sorted key/fixup table search unit.
// ----------------------------------------------------------------------------
`default_nettype none

package sktbl_pkg;

  localparam int unsigned DEFAULT_TABLE_DEPTH = 256;
  localparam int unsigned DEFAULT_ADDR_BITS   = 32;

  localparam int unsigned CMD_W    = 2;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned FIELD_W  = 32;

  // command codes; the fourth code does nothing and answers ok
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd2;

  localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_MISSING = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,  // waiting for an item
    ST_INS,   // insertion step: compare and shift one entry up
    ST_PUT,   // write the new pair at its place
    ST_LKP,   // binary search probe
    ST_RESP   // hand the result to the output register
  } sktbl_state_e;

  typedef struct packed {
    logic lt;  // stored key below search key
    logic eq;  // stored key equal to search key
  } sktbl_cmp_t;

endpackage

`default_nettype wire

// ----- rtl/sktbl_in_if.sv -----
// ----------------------------------------------------------------------------
// Command channel
// Valid/ready channel carrying one command item into the table.
// ----------------------------------------------------------------------------
`default_nettype none

interface sktbl_in_if;

  logic                                valid;
  logic                                ready;
  logic [sktbl_pkg::CMD_W-1:0]         cmd;
  logic [sktbl_pkg::FIELD_W-1:0]       key_address;
  logic [sktbl_pkg::FIELD_W-1:0]       fixup_address;

  modport source (output valid, output cmd, output key_address, output fixup_address,
                  input ready);
  modport sink (input valid, input cmd, input key_address, input fixup_address,
                output ready);

endinterface

`default_nettype wire

// ----- rtl/sktbl_out_if.sv -----
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one result item out of the table.
// ----------------------------------------------------------------------------
`default_nettype none

interface sktbl_out_if;

  logic                                valid;
  logic                                ready;
  logic [sktbl_pkg::STATUS_W-1:0]      status;
  logic [sktbl_pkg::FIELD_W-1:0]       found_fixup;

  modport source (output valid, output status, output found_fixup, input ready);
  modport sink (input valid, input status, input found_fixup, output ready);

endinterface

`default_nettype wire

// ----- rtl/sorted_key_value_table_search_unit.sv -----
// Steps: clear and the unused command go straight to the result; insert moves each greater
//   entry up one place from the end, then writes the pair (at once on an empty table, no write
//   when full); lookup makes at most ceil(log2(entries+1)) probes, one a cycle.
// Throughput: one item at a time; the next is taken the cycle after the result is
//   loaded, and a stalled output register holds the sequencer until it frees.
// Reset: entry count and control cleared at once; RAM left as is, never read above the count.
// ----------------------------------------------------------------------------
// Sorted key/fixup table search unit
// Keeps (key, fixup) pairs in ascending unsigned key order in two RAMs;
// insertion-sort insert, binary search lookup, clear.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_key_value_table_search_unit #(
  parameter int unsigned TABLE_DEPTH = sktbl_pkg::DEFAULT_TABLE_DEPTH,
  parameter int unsigned ADDR_BITS   = sktbl_pkg::DEFAULT_ADDR_BITS
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  sktbl_in_if.sink          in_i,
  sktbl_out_if.source       out_o
);

  localparam int unsigned IdxW = $clog2(TABLE_DEPTH);
  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);

  // ---------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------
  sktbl_pkg::sktbl_state_e state_q, state_d;

  logic [CntW-1:0]      count_q, count_d;   // occupied entries
  logic [IdxW-1:0]      pos_q, pos_d;       // insertion hole
  logic [CntW-1:0]      lo_q, lo_d;         // search window [lo, hi)
  logic [CntW-1:0]      hi_q, hi_d;
  logic [IdxW-1:0]      mid_q, mid_d;       // entry probed this cycle
  logic [ADDR_BITS-1:0] key_q, key_d;
  logic [ADDR_BITS-1:0] fix_q, fix_d;

  // result waiting for the output register
  logic [sktbl_pkg::STATUS_W-1:0] res_status_q, res_status_d;
  logic [sktbl_pkg::FIELD_W-1:0]  res_fix_q, res_fix_d;

  // output register
  logic                           out_valid_q, out_valid_d;
  logic [sktbl_pkg::STATUS_W-1:0] out_status_q, out_status_d;
  logic [sktbl_pkg::FIELD_W-1:0]  out_fix_q, out_fix_d;

  // RAM ports, shared by key and fixup stores
  logic                 wr_en;
  logic [IdxW-1:0]      wr_addr;
  logic [ADDR_BITS-1:0] wr_key, wr_fix;
  logic                 rd_en;
  logic [IdxW-1:0]      rd_addr;
  logic [ADDR_BITS-1:0] rd_key, rd_fix;

  sktbl_pkg::sktbl_cmp_t cmp;

  // search arithmetic
  logic [CntW-1:0] lo_n, hi_n, span_n, mid_ext;
  logic [CntW-1:0] span0;
  logic            out_free;

  // ---------------------------------------------------------------------------
  // Storage and the shared compare unit
  // ---------------------------------------------------------------------------
  sktbl_ram #(
    .Width (ADDR_BITS),
    .Depth (TABLE_DEPTH)
  ) u_key_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_key),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_key)
  );

  sktbl_ram #(
    .Width (ADDR_BITS),
    .Depth (TABLE_DEPTH)
  ) u_fix_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_fix),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_fix)
  );

  sktbl_cmp #(
    .AddrBits (ADDR_BITS)
  ) u_cmp (
    .stored_key_i (rd_key),
    .search_key_i (key_q),
    .res_o        (cmp)
  );

  // ---------------------------------------------------------------------------
  // Handshakes
  // ---------------------------------------------------------------------------
  // Ready only between items; a finished result sitting in the output
  // register does not block the next item.
  assign in_i.ready        = (state_q == sktbl_pkg::ST_IDLE);
  assign out_o.valid       = out_valid_q;
  assign out_o.status      = out_status_q;
  assign out_o.found_fixup = out_fix_q;

  assign out_free = !out_valid_q || out_o.ready;

  // Next search window after a probe that missed: above the probe if the
  // stored key is lower, else below it. Midpoint is lo + (hi-1-lo)/2.
  assign mid_ext = CntW'(mid_q);
  assign lo_n    = cmp.lt ? CntW'(mid_ext + 1'b1) : lo_q;
  assign hi_n    = cmp.lt ? hi_q : mid_ext;
  assign span_n  = CntW'(hi_n - lo_n - 1'b1);
  // first probe over [0, count)
  assign span0   = CntW'(count_q - 1'b1);

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    pos_d        = pos_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    mid_d        = mid_q;
    key_d        = key_q;
    fix_d        = fix_q;
    res_status_d = res_status_q;
    res_fix_d    = res_fix_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    out_status_d = out_status_q;
    out_fix_d    = out_fix_q;
    wr_en        = 1'b0;
    wr_addr      = pos_q;
    wr_key       = key_q;
    wr_fix       = fix_q;
    rd_en        = 1'b0;
    rd_addr      = mid_q;

    unique case (state_q)
      sktbl_pkg::ST_IDLE: begin
        if (in_i.valid) begin
          key_d        = ADDR_BITS'(in_i.key_address);
          fix_d        = ADDR_BITS'(in_i.fixup_address);
          res_status_d = sktbl_pkg::STAT_OK;
          res_fix_d    = '0;
          state_d      = sktbl_pkg::ST_RESP;
          unique case (in_i.cmd)
            sktbl_pkg::CMD_CLEAR: begin
              count_d = '0;
            end
            sktbl_pkg::CMD_INSERT: begin
              if (count_q == CntW'(TABLE_DEPTH)) begin
                res_status_d = sktbl_pkg::STAT_FULL;
              end else if (count_q == '0) begin
                pos_d   = '0;
                state_d = sktbl_pkg::ST_PUT;
              end else begin
                // hole at the end; look at the last entry first
                pos_d   = IdxW'(count_q);
                rd_en   = 1'b1;
                rd_addr = IdxW'(span0);
                state_d = sktbl_pkg::ST_INS;
              end
            end
            sktbl_pkg::CMD_LOOKUP: begin
              if (count_q == '0) begin
                res_status_d = sktbl_pkg::STAT_MISSING;
              end else begin
                lo_d    = '0;
                hi_d    = count_q;
                mid_d   = IdxW'(span0 >> 1);
                rd_en   = 1'b1;
                rd_addr = IdxW'(span0 >> 1);
                state_d = sktbl_pkg::ST_LKP;
              end
            end
            default: begin
              // unused command: no change, answers ok
            end
          endcase
        end
      end

      sktbl_pkg::ST_INS: begin
        // entry pos-1 is on the read port; move it up if its key is greater
        if (!cmp.lt && !cmp.eq) begin
          wr_en   = 1'b1;
          wr_addr = pos_q;
          wr_key  = rd_key;
          wr_fix  = rd_fix;
          pos_d   = IdxW'(pos_q - 1'b1);
          if (pos_q > IdxW'(1)) begin
            rd_en   = 1'b1;
            rd_addr = IdxW'(pos_q - 1'b1 - 1'b1);
          end else begin
            state_d = sktbl_pkg::ST_PUT;
          end
        end else begin
          state_d = sktbl_pkg::ST_PUT;
        end
      end

      sktbl_pkg::ST_PUT: begin
        wr_en   = 1'b1;
        wr_addr = pos_q;
        count_d = CntW'(count_q + 1'b1);
        state_d = sktbl_pkg::ST_RESP;
      end

      sktbl_pkg::ST_LKP: begin
        if (cmp.eq) begin
          res_status_d = sktbl_pkg::STAT_OK;
          res_fix_d    = sktbl_pkg::FIELD_W'(rd_fix);
          state_d      = sktbl_pkg::ST_RESP;
        end else if (lo_n < hi_n) begin
          // next probe issued straight away: one probe per cycle
          lo_d    = lo_n;
          hi_d    = hi_n;
          mid_d   = IdxW'(lo_n + (span_n >> 1));
          rd_en   = 1'b1;
          rd_addr = IdxW'(lo_n + (span_n >> 1));
        end else begin
          res_status_d = sktbl_pkg::STAT_MISSING;
          res_fix_d    = '0;
          state_d      = sktbl_pkg::ST_RESP;
        end
      end

      sktbl_pkg::ST_RESP: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_fix_d    = res_fix_q;
          state_d      = sktbl_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = sktbl_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sktbl_pkg::ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    pos_q        <= pos_d;
    lo_q         <= lo_d;
    hi_q         <= hi_d;
    mid_q        <= mid_d;
    key_q        <= key_d;
    fix_q        <= fix_d;
    res_status_q <= res_status_d;
    res_fix_q    <= res_fix_d;
    out_status_q <= out_status_d;
    out_fix_q    <= out_fix_d;
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_write_states: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (state_q == sktbl_pkg::ST_INS || state_q == sktbl_pkg::ST_PUT))
    else $error("table written outside insert");

  a_probe_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == sktbl_pkg::ST_LKP |->
      (lo_q <= mid_ext && mid_ext < hi_q && hi_q <= count_q))
    else $error("probe outside search window");

  a_put_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == sktbl_pkg::ST_PUT |=> count_q == CntW'($past(count_q) + 1'b1))
    else $error("insert did not grow table by one");

endmodule

`default_nettype wire

// ----- rtl/sktbl_ram.sv -----
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port, registered read data, no reset of contents.
// ----------------------------------------------------------------------------
`default_nettype none

module sktbl_ram #(
  parameter int unsigned Width = sktbl_pkg::DEFAULT_ADDR_BITS,
  parameter int unsigned Depth = sktbl_pkg::DEFAULT_TABLE_DEPTH,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             wr_en_i,
  input  wire logic [AddrW-1:0] wr_addr_i,
  input  wire logic [Width-1:0] wr_data_i,
  input  wire logic             rd_en_i,
  input  wire logic [AddrW-1:0] rd_addr_i,
  output logic      [Width-1:0] rd_data_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/sktbl_cmp.sv -----
// ----------------------------------------------------------------------------
// Key comparator
// Shared unsigned compare of a stored key against the item's key; serves
// both the insertion step and every binary search probe.
// ----------------------------------------------------------------------------
`default_nettype none

module sktbl_cmp #(
  parameter int unsigned AddrBits = sktbl_pkg::DEFAULT_ADDR_BITS
) (
  input  wire logic [AddrBits-1:0] stored_key_i,
  input  wire logic [AddrBits-1:0] search_key_i,
  output sktbl_pkg::sktbl_cmp_t    res_o
);

  always_comb begin
    res_o.lt = stored_key_i < search_key_i;
    res_o.eq = stored_key_i == search_key_i;
  end

endmodule

`default_nettype wire

// ----- tb/sv/tb_sorted_key_value_table_search_unit.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sorted key table search unit testbench
// Sends clear, insert, lookup and unused-command items through the command
// channel and checks every result item against a shadow copy of the sorted
// table. Both channels idle at random. Runs corner cases, a fill to capacity
// and mixed random traffic.
// ----------------------------------------------------------------------------

module tb_sorted_key_value_table_search_unit;
  import sktbl_pkg::*;

  localparam int unsigned DEPTH = DEFAULT_TABLE_DEPTH;
  // the fourth command code has no name in the package
  localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;
  // longest insert shifts the whole table; wait that long after the last result
  localparam int unsigned DRAIN_CYCLES = DEPTH + 8;
  localparam int unsigned POOL_SIZE = 12;
  localparam int unsigned RANDOM_ITEMS = 260;

  typedef logic [FIELD_W-1:0] addr_t;
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    addr_t               fixup;
  } answer_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  sktbl_in_if  cmd_ch ();
  sktbl_out_if res_ch ();

  sorted_key_value_table_search_unit u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (cmd_ch),
    .out_o  (res_ch)
  );

  // Shadow table: kept sorted exactly as the block keeps its RAMs.
  addr_t       shadow_keys   [DEPTH];
  addr_t       shadow_fixups [DEPTH];
  int unsigned shadow_count = 0;

  answer_t     answers_due [$];   // one per accepted command, oldest first
  int unsigned fail_count = 0;
  bit          quiet = 1'b0;      // set: neither side idles
  addr_t       key_pool [POOL_SIZE];

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #6_000_000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic int unsigned draw_wait();
    return quiet ? 0 : $urandom_range(0, 8);
  endfunction

  // Half the keys come from a small pool, so duplicates and hits are common.
  function automatic addr_t random_key();
    return ($urandom_range(0, 1) == 0) ? key_pool[$urandom_range(0, POOL_SIZE - 1)]
                                       : addr_t'($urandom());
  endfunction

  function automatic addr_t stored_key();
    return shadow_keys[$urandom_range(0, shadow_count - 1)];
  endfunction

  // Applies one command to the shadow table and returns the answer it gives.
  function automatic answer_t predict_answer(input logic [CMD_W-1:0] cmd,
                                             input addr_t key, input addr_t fixup);
    answer_t ans;
    int      pos;
    int      lo;
    int      hi;
    int      mid;
    ans = '{status: STAT_OK, fixup: '0};
    case (cmd)
      CMD_CLEAR: begin
        shadow_count = 0;
      end
      CMD_INSERT: begin
        if (shadow_count >= DEPTH) begin
          ans.status = STAT_FULL;
        end else begin
          // larger keys move up one place; equal keys stay below the new one
          pos = shadow_count;
          while (pos > 0 && key < shadow_keys[pos - 1]) begin
            shadow_keys[pos]   = shadow_keys[pos - 1];
            shadow_fixups[pos] = shadow_fixups[pos - 1];
            pos--;
          end
          shadow_keys[pos]   = key;
          shadow_fixups[pos] = fixup;
          shadow_count++;
        end
      end
      CMD_LOOKUP: begin
        ans.status = STAT_MISSING;
        lo = 0;
        hi = int'(shadow_count) - 1;
        while (lo <= hi) begin
          mid = lo + (hi - lo) / 2;
          if (shadow_keys[mid] == key) begin
            ans.status = STAT_OK;
            ans.fixup  = shadow_fixups[mid];
            break;
          end else if (shadow_keys[mid] < key) begin
            lo = mid + 1;
          end else begin
            hi = mid - 1;
          end
        end
      end
      default: ;  // unused command: table untouched, answers ok
    endcase
    return ans;
  endfunction

  // Entered and left just after a falling edge. Valid stays high when the
  // next item follows with no gap.
  task automatic send_item(input logic [CMD_W-1:0] cmd, input addr_t key,
                           input addr_t fixup);
    int unsigned gap;
    gap = draw_wait();
    if (gap != 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    cmd_ch.valid         <= 1'b1;
    cmd_ch.cmd           <= cmd;
    cmd_ch.key_address   <= key;
    cmd_ch.fixup_address <= fixup;
    do @(posedge clk_i); while (!cmd_ch.ready);
    answers_due.push_back(predict_answer(cmd, key, fixup));
    @(negedge clk_i);
  endtask

  // Sender holds off until every outstanding result has come back.
  task automatic wait_for_answers();
    cmd_ch.valid <= 1'b0;
    while (answers_due.size() != 0) @(negedge clk_i);
  endtask

  // Empty table, unused command, key and fixup extremes, duplicates, a stored
  // fixup of zero, and lookups after a clear.
  task automatic test_corner_cases();
    send_item(CMD_LOOKUP, '0, '0);
    send_item(CMD_LOOKUP, '1, '1);
    send_item(CMD_NOP, '1, '1);
    send_item(CMD_INSERT, 32'h8000_0000, 32'h0000_0000);
    send_item(CMD_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(CMD_INSERT, 32'h0000_0000, 32'h1234_5678);
    send_item(CMD_INSERT, 32'h7FFF_FFFF, 32'hA5A5_A5A5);
    send_item(CMD_INSERT, 32'h8000_0000, 32'h5A5A_5A5A);
    send_item(CMD_INSERT, 32'h8000_0000, 32'h0000_0001);
    send_item(CMD_LOOKUP, 32'h8000_0000, '0);
    send_item(CMD_LOOKUP, 32'h0000_0000, '1);
    send_item(CMD_LOOKUP, 32'hFFFF_FFFF, '0);
    send_item(CMD_LOOKUP, 32'h7FFF_FFFF, '0);
    send_item(CMD_LOOKUP, 32'h8000_0001, '0);
    send_item(CMD_LOOKUP, 32'h0000_0001, '0);
    send_item(CMD_CLEAR, '1, '1);
    send_item(CMD_LOOKUP, 32'h0000_0000, '0);
    send_item(CMD_INSERT, 32'hFFFF_FFFF, 32'h0000_0000);
    send_item(CMD_LOOKUP, 32'hFFFF_FFFF, '1);
    send_item(CMD_NOP, '0, '0);
    send_item(CMD_CLEAR, '0, '0);
  endtask

  // Fill every entry, get inserts refused, then search the full table.
  task automatic test_full_table();
    send_item(CMD_CLEAR, '0, '0);
    for (int unsigned i = 0; i < DEPTH; i++) begin
      send_item(CMD_INSERT, random_key(), addr_t'($urandom()));
    end
    send_item(CMD_INSERT, 32'h0000_0000, 32'h1111_1111);
    send_item(CMD_INSERT, 32'hFFFF_FFFF, 32'h2222_2222);
    send_item(CMD_LOOKUP, shadow_keys[0], '0);
    send_item(CMD_LOOKUP, shadow_keys[DEPTH - 1], '0);
    for (int unsigned i = 0; i < 8; i++) begin
      send_item(CMD_LOOKUP, stored_key(), addr_t'($urandom()));
    end
    send_item(CMD_LOOKUP, addr_t'($urandom()), '0);
    wait_for_answers();
    send_item(CMD_CLEAR, addr_t'($urandom()), addr_t'($urandom()));
  endtask

  // Mostly inserts and lookups of stored or nearby keys; clears keep the
  // table at varied sizes so the search runs to different depths.
  task automatic test_random_traffic(input int unsigned n_items);
    int unsigned pick;
    int unsigned how;
    addr_t       key;
    addr_t       fixup;
    for (int unsigned i = 0; i < n_items; i++) begin
      quiet = (i >= 60 && i < 100);
      if (i == n_items / 2) wait_for_answers();
      pick  = $urandom_range(0, 99);
      fixup = ($urandom_range(0, 9) == 0) ? '0 : addr_t'($urandom());
      if (pick < 3) begin
        send_item(CMD_CLEAR, addr_t'($urandom()), fixup);
      end else if (pick < 6) begin
        send_item(CMD_NOP, addr_t'($urandom()), fixup);
      end else if (pick < 52) begin
        send_item(CMD_INSERT, random_key(), fixup);
      end else begin
        how = $urandom_range(0, 99);
        if (shadow_count == 0 || how >= 85) begin
          key = random_key();
        end else if (how < 70) begin
          key = stored_key();
        end else begin
          // just beside a stored key: mostly a miss next to a hit
          key = stored_key() + (($urandom_range(0, 1) == 0) ? addr_t'(1) : '1);
        end
        send_item(CMD_LOOKUP, key, fixup);
      end
    end
    quiet = 1'b0;
  endtask

  // Result side: random stall before each item, then ready until it comes.
  initial begin : result_sink
    int unsigned stall;
    res_ch.ready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      stall = draw_wait();
      if (stall != 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!res_ch.valid);
      @(negedge clk_i);
    end
  end

  // Every accepted result is matched against the oldest outstanding answer.
  always @(posedge clk_i) begin : check_result
    answer_t due;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      if (answers_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, got status %0d fixup %h",
                 $time, res_ch.status, res_ch.found_fixup);
        fail_count++;
      end else begin
        due = answers_due.pop_front();
        if (res_ch.status !== due.status) begin
          $display("%0t: status mismatch, expected %0d, got %0d",
                   $time, due.status, res_ch.status);
          fail_count++;
        end
        if (res_ch.found_fixup !== due.fixup) begin
          $display("%0t: found_fixup mismatch, expected %h, got %h",
                   $time, due.fixup, res_ch.found_fixup);
          fail_count++;
        end
      end
    end
  end

  initial begin
    cmd_ch.valid         = 1'b0;
    cmd_ch.cmd           = CMD_CLEAR;
    cmd_ch.key_address   = '0;
    cmd_ch.fixup_address = '0;
    key_pool[0] = '0;
    key_pool[1] = '1;
    key_pool[2] = 32'h8000_0000;
    key_pool[3] = 32'h7FFF_FFFF;
    for (int unsigned i = 4; i < POOL_SIZE; i++) key_pool[i] = addr_t'($urandom());

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_corner_cases();
    test_full_table();
    test_random_traffic(RANDOM_ITEMS);

    // Let the last results out, then watch for stray ones.
    wait_for_answers();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
